>>> hdl/alc_pkg.sv
// Package for the ambient light lux calculation block.
// Holds item types, field widths, coefficient tables and register indexes.
// No dependencies; every other file imports it.
package alc_pkg;

  localparam int unsigned VIS_W      = 16;
  localparam int unsigned LUX_W      = 31;
  localparam int unsigned REGION_W   = 3;
  localparam int unsigned GAIN_W     = 2;
  localparam int unsigned ICYC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned LUX_FRAC_BITS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATION_CYCLE = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd0;
  localparam logic [ICYC_W-1:0] ICYC_RESET = 8'd245;

  localparam logic [REGION_W-1:0] REGION_VIS_ZERO = 3'd4;
  localparam logic [REGION_W-1:0] REGION_RANGE    = 3'd5;

  localparam int unsigned MUL_W   = 28;
  localparam int unsigned DIFF_W  = 27;
  localparam int unsigned PROD_W  = 37;
  localparam int unsigned QUOT_W  = LUX_W;
  localparam int unsigned DIV_W   = 13;
  localparam int unsigned REM_W   = DIV_W;

  localparam int unsigned LUX_SCALE_NUM = 1026;
  localparam int unsigned COEF_SHIFT    = 10;
  localparam int unsigned DIV_TEN       = 10;

  localparam int unsigned ITIME_X_W         = 19;
  localparam int unsigned ITIME_PROD_W      = 39;
  localparam int unsigned ITIME_W           = 10;
  localparam int unsigned ITIME_NUM         = 1687;
  localparam int unsigned ITIME_RECIP       = 858994;
  localparam int unsigned ITIME_RECIP_SHIFT = 29;
  localparam int unsigned ICYC_SPAN         = 256;

  localparam int unsigned PIPE_LATENCY = QUOT_W + 6;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  typedef struct packed {
    logic [VIS_W-1:0] visible_count;
    logic [VIS_W-1:0] infrared_count;
  } in_item_t;

  typedef struct packed {
    logic [LUX_W-1:0]    lux_value;
    logic [REGION_W-1:0] region;
  } out_item_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [QUOT_W-1:0]   work;
    logic [REGION_W-1:0] region;
    logic                force_zero;
    logic                sat;
  } div_item_t;

  function automatic logic [10:0] vis_coef(input logic [1:0] band);
    logic [10:0] c;
    unique case (band)
      2'd0: c = 11'd1321;
      2'd1: c = 11'd814;
      2'd2: c = 11'd522;
      default: c = 11'd283;
    endcase
    return c;
  endfunction

  function automatic logic [11:0] ir_coef(input logic [1:0] band);
    logic [11:0] c;
    unique case (band)
      2'd0: c = 12'd2799;
      2'd1: c = 12'd880;
      2'd2: c = 12'd353;
      default: c = 12'd133;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] band_limit_x100(input logic [1:0] band);
    logic [7:0] c;
    unique case (band)
      2'd0: c = 8'd26;
      2'd1: c = 8'd55;
      2'd2: c = 8'd109;
      default: c = 8'd213;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] gain_shift(input logic [GAIN_W-1:0] code);
    logic [2:0] s;
    unique case (code)
      2'd0: s = 3'd0;
      2'd1: s = 3'd1;
      2'd2: s = 3'd6;
      default: s = 3'd7;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/alc_divider.sv
// Pipelined restoring divider for the lux block: one quotient bit per stage.
// Divides the scaled weighted difference by ten times the integration time.
// Depends on alc_pkg for the item type and widths.
module alc_divider
  import alc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  div_item_t        in_stage,
  input  logic [DIV_W-1:0] divisor,
  output logic             out_valid,
  output div_item_t        out_stage
);

  logic      [QUOT_W:0] valid_r;
  logic      [QUOT_W:0] valid_nxt;
  div_item_t            stage_r   [QUOT_W:0];
  div_item_t            stage_nxt [QUOT_W:0];

  always_comb begin
    logic [REM_W:0] trial;
    logic           ge;
    valid_nxt    = {valid_r[QUOT_W-1:0], in_valid};
    stage_nxt[0] = in_stage;
    for (int i = 1; i <= QUOT_W; i++) begin
      trial = {stage_r[i-1].rem, stage_r[i-1].work[QUOT_W-1]};
      ge    = (trial >= {1'b0, divisor});
      stage_nxt[i]      = stage_r[i-1];
      stage_nxt[i].rem  = ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
      stage_nxt[i].work = {stage_r[i-1].work[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= QUOT_W; i++) begin
      stage_r[i] <= stage_nxt[i];
    end
  end

  assign out_valid = valid_r[QUOT_W];
  assign out_stage = stage_r[QUOT_W];

endmodule

>>> hdl/ambient_light_lux_calculation.sv
// Ambient light lux calculation: one item is taken every cycle while busy is low, and each
// item gives one out_strobe result; the depth is set by the 31 quotient stages of the long divider
// plus band, multiply, difference, scale, divider input and output stages.
// Reset is synchronous: pipeline valid bits clear, gain_code returns to 0 and
// integration_cycle to 245, busy is high during reset and for one cycle after it.
// A configuration write may be followed by an item in the next cycle.
module ambient_light_lux_calculation
  import alc_pkg::*;
#(
  parameter int unsigned LUX_FRAC_BITS = LUX_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SW = PROD_W + LUX_FRAC_BITS;
  localparam int unsigned NW = SW - COEF_SHIFT;
  localparam int unsigned NX = (NW > QUOT_W + 1) ? NW : QUOT_W + 1;
  localparam int unsigned HW = NX - QUOT_W;
  localparam int unsigned CW = (HW > DIV_W) ? HW : DIV_W;

  typedef struct packed {
    logic [VIS_W-1:0]    vis;
    logic [VIS_W-1:0]    ir;
    logic [1:0]          band;
    logic [REGION_W-1:0] region;
    logic                kill;
  } s1_t;

  typedef struct packed {
    logic [MUL_W-1:0]    pos;
    logic [MUL_W-1:0]    neg;
    logic [REGION_W-1:0] region;
    logic                kill;
  } s2_t;

  typedef struct packed {
    logic [DIFF_W-1:0]   diff;
    logic [REGION_W-1:0] region;
    logic                zero;
  } s3_t;

  typedef struct packed {
    logic [PROD_W-1:0]   prod;
    logic [REGION_W-1:0] region;
    logic                zero;
  } s4_t;

  logic                    busy_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [ICYC_W-1:0]       icyc_r;
  logic [ITIME_X_W-1:0]    itx_r;
  logic [ITIME_X_W-1:0]    itx_nxt;
  logic [ITIME_W-1:0]      itime_r;
  logic [ITIME_W-1:0]      itime_nxt;
  logic [DIV_W-1:0]        divisor_r;
  logic [DIV_W-1:0]        divisor_nxt;
  logic [ITIME_PROD_W-1:0] itime_prod;

  logic      in_fire;
  logic      v1_r, v2_r, v3_r, v4_r;
  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  s3_t       s3_r, s3_nxt;
  s4_t       s4_r, s4_nxt;
  div_item_t div_in;
  logic      div_valid;
  div_item_t div_out;

  logic [SW-1:0]    scaled;
  logic [SW-1:0]    shifted;
  logic [4:0]       shift_amt;
  logic [NX-1:0]    nval;
  logic [HW-1:0]    nhi;
  logic             ovf;

  logic      out_strobe_r;
  out_item_t out_item_r, out_item_nxt;

  assign in_fire   = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      icyc_r <= ICYC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GAIN_CODE:         gain_r <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRATION_CYCLE: icyc_r <= cfg_data[ICYC_W-1:0];
        default: ;
      endcase
    end
  end

  // Integration time is floor(1687 * cycles / 625), done by reciprocal multiply.
  always_comb begin
    itx_nxt     = ITIME_X_W'(20'(ITIME_NUM) * (20'(ICYC_SPAN) - 20'(icyc_r)));
    itime_prod  = ITIME_PROD_W'(itx_r) * ITIME_PROD_W'(ITIME_RECIP);
    itime_nxt   = ITIME_W'(itime_prod >> ITIME_RECIP_SHIFT);
    divisor_nxt = DIV_W'(itime_r) * DIV_W'(DIV_TEN);
  end

  always_ff @(posedge clk) begin
    itx_r     <= itx_nxt;
    itime_r   <= itime_nxt;
    divisor_r <= divisor_nxt;
  end

  always_comb begin
    logic [3:0]  lt;
    logic [1:0]  band;
    logic        found;
    logic [23:0] ir100;
    band  = 2'd0;
    found = 1'b0;
    ir100 = 24'(in_item.infrared_count) * 24'd100;
    for (int b = 3; b >= 0; b--) begin
      lt[b] = ir100 < (24'(in_item.visible_count) * 24'(band_limit_x100(2'(b))));
      if (lt[b]) begin
        band  = 2'(b);
        found = 1'b1;
      end
    end
    s1_nxt.vis  = in_item.visible_count;
    s1_nxt.ir   = in_item.infrared_count;
    s1_nxt.band = band;
    if (in_item.visible_count == '0) begin
      s1_nxt.region = REGION_VIS_ZERO;
      s1_nxt.kill   = 1'b1;
    end else if (!found) begin
      s1_nxt.region = REGION_RANGE;
      s1_nxt.kill   = 1'b1;
    end else begin
      s1_nxt.region = {1'b0, band};
      s1_nxt.kill   = 1'b0;
    end
  end

  always_comb begin
    s2_nxt.pos    = MUL_W'(s1_r.vis) * MUL_W'(vis_coef(s1_r.band));
    s2_nxt.neg    = MUL_W'(s1_r.ir) * MUL_W'(ir_coef(s1_r.band));
    s2_nxt.region = s1_r.region;
    s2_nxt.kill   = s1_r.kill;

    s3_nxt.diff   = DIFF_W'(s2_r.pos - s2_r.neg);
    s3_nxt.region = s2_r.region;
    s3_nxt.zero   = s2_r.kill || (s2_r.pos <= s2_r.neg);

    s4_nxt.prod   = PROD_W'(s3_r.diff) * PROD_W'(LUX_SCALE_NUM);
    s4_nxt.region = s3_r.region;
    s4_nxt.zero   = s3_r.zero;
  end

  // The power-of-two part of the divisor (coefficient scale and gain) is a shift.
  always_comb begin
    scaled    = SW'(s4_r.prod) << LUX_FRAC_BITS;
    shift_amt = 5'(COEF_SHIFT) + 5'(gain_shift(gain_r));
    shifted   = scaled >> shift_amt;
    nval      = NX'(shifted[NW-1:0]);
    nhi       = nval[NX-1:QUOT_W];
    ovf       = CW'(nhi) >= CW'(divisor_r);

    div_in.rem        = REM_W'(nhi);
    div_in.work       = nval[QUOT_W-1:0];
    div_in.region     = s4_r.region;
    div_in.force_zero = s4_r.zero;
    div_in.sat        = ovf && !s4_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
  end

  alc_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_stage  (div_in),
    .divisor   (divisor_r),
    .out_valid (div_valid),
    .out_stage (div_out)
  );

  always_comb begin
    out_item_nxt.region = div_out.region;
    if (div_out.force_zero) begin
      out_item_nxt.lux_value = '0;
    end else if (div_out.sat) begin
      out_item_nxt.lux_value = LUX_MAX;
    end else begin
      out_item_nxt.lux_value = div_out.work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_accept_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##PIPE_LATENCY out_strobe)
    else $error("accepted item did not produce a result on time");

  a_result_has_item : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_fire, PIPE_LATENCY))
    else $error("result without a matching accepted item");

  a_special_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.region == REGION_VIS_ZERO || out_item.region == REGION_RANGE)
    |-> out_item.lux_value == '0)
    else $error("special region with nonzero lux");

endmodule
